### src/block_transfer_receiver_unit_defines.svh
// Assertion macros for the block transfer receiver
`ifndef BLOCK_TRANSFER_RECEIVER_UNIT_DEFINES_SVH
`define BLOCK_TRANSFER_RECEIVER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BTR_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BTR_ASSERT(label, clk, rst_n, prop, msg)
`define BTR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### src/btr_pkg.sv
`default_nettype none
package btr_pkg;
	localparam int BLOCK_BYTES = 1024;
	localparam int OFFSET_BITS = 27;
	localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int CNT_BITS = BLK_SHIFT + 1;
	localparam logic [31:0] POLY = 32'hedb88320;
	localparam logic [31:0] SYNC_WORD = 32'hc33caa55;
	localparam logic [31:0] MAGIC_WORD = 32'h214d5246;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;
	localparam logic [31:0] MIN_SIZE = 32'd20;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0, PH_SYNC = 3'd1, PH_MAGIC = 3'd2,
		PH_FHDR = 3'd3, PH_DATA = 3'd4, PH_DONE = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_WRITE = 3'd0, K_SIZE_ERR = 3'd1, K_HDR_OK = 3'd2, K_SYNC = 3'd3,
		K_ACK = 3'd4, K_NAK = 3'd5, K_CRC_OK = 3'd6, K_CRC_ERR = 3'd7
	} kind_t;

	typedef enum logic {REG_LOAD_BASE = 1'b0, REG_MAX_SIZE = 1'b1} reg_idx_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] write_address;
		logic [7:0]  write_data;
		logic [31:0] echo_block;
		logic [26:0] total_size;
		logic        last;
	} result_t;

	// Up to three results caused by one byte
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
		result_t    r2;
	} bundle_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = (c >> 1) ^ (POLY & {32{c[0]}});
		return c;
	endfunction
endpackage
`default_nettype wire

### src/btr_rx_if.sv
`default_nettype none
interface btr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### src/btr_res_if.sv
`default_nettype none
interface btr_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] write_address;
	logic [7:0]  write_data;
	logic [31:0] echo_block;
	logic [26:0] total_size;
	logic        last;
	modport source (output valid, output kind, output write_address, output write_data,
		output echo_block, output total_size, output last, input ready);
	modport sink (input valid, input kind, input write_address, input write_data,
		input echo_block, input total_size, input last, output ready);
endinterface
`default_nettype wire

### src/btr_core.sv
`default_nettype none
// Protocol state; turns one accepted byte into a bundle of up to three results
module btr_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      b,
	input  wire logic [31:0]     load_base,
	input  wire logic [26:0]     size_limit,
	output btr_pkg::bundle_t     bundle
);
	localparam int CB = btr_pkg::CNT_BITS;
	localparam int OB = btr_pkg::OFFSET_BITS;

	btr_pkg::phase_t phase_q, phase_d;
	logic [CB-1:0] cnt_q, cnt_d;
	logic [31:0] sw_q, sw_d, w;
	logic [31:0] size_q, size_d, ecrc_q, ecrc_d, fnum_q, fnum_d, fchk_q, fchk_d;
	logic        bad_q, bad_d;
	logic [16:0] nblk_q, nblk_d;
	logic [OB-1:0] rcv_q, rcv_d, foff_q, foff_d;
	logic [31:0] rcrc_q, rcrc_d, ccrc_q, ccrc_d, kcrc_q, kcrc_d;
	logic [CB-1:0] flen_q, flen_d;
	logic [1:0]  flags_q, flags_d;

	// frame header evaluation terms
	logic valid_h, cur_h, dup_h;
	logic [31:0] off32, len32, nblk32;
	logic [OB-1:0] off_d;
	// data terms
	logic [31:0] kc_n, cc_n, rcrc_n;
	logic [CB-1:0] cnt_n;
	logic [OB-1:0] rcv_n;
	logic ok_chunk;

	function automatic btr_pkg::result_t mk(input btr_pkg::kind_t k, input logic [31:0] a,
		input logic [7:0] d, input logic [31:0] blk, input logic [26:0] s);
		btr_pkg::result_t r;
		r.kind = k;
		r.write_address = a;
		r.write_data = d;
		r.echo_block = blk;
		r.total_size = s;
		r.last = 1'b0;
		return r;
	endfunction

	always_comb begin
		w = {b, sw_q[31:8]};
		nblk32 = {15'd0, nblk_q};
		valid_h = !bad_q && (w == ~fchk_q);
		cur_h = valid_h && (fnum_q == nblk32);
		dup_h = valid_h && (nblk_q != 17'd0) && (fnum_q == nblk32 - 32'd1);
		off_d = dup_h ? fnum_q[OB-1:0] << btr_pkg::BLK_SHIFT : rcv_q;
		off32 = 32'(off_d);
		len32 = (size_q > off32) ? size_q - off32 : 32'd0;
		if (len32 > 32'(btr_pkg::BLOCK_BYTES)) len32 = 32'(btr_pkg::BLOCK_BYTES);
		if (len32 == 32'd0) len32 = 32'd1;
		kc_n = btr_pkg::crc_byte(kcrc_q, b);
		cc_n = btr_pkg::crc_byte(ccrc_q, b);
		cnt_n = cnt_q + CB'(1);
		ok_chunk = (flags_q != 2'd0) && ((kc_n ^ btr_pkg::ALL_ONES) == fchk_q);
		rcrc_n = (ok_chunk && flags_q[0]) ? cc_n : rcrc_q;
		rcv_n = (ok_chunk && flags_q[0]) ? rcv_q + OB'(flen_q) : rcv_q;

		phase_d = phase_q; cnt_d = cnt_q; sw_d = w; size_d = size_q; ecrc_d = ecrc_q;
		bad_d = bad_q; fnum_d = fnum_q; fchk_d = fchk_q; nblk_d = nblk_q; rcv_d = rcv_q;
		rcrc_d = rcrc_q; ccrc_d = ccrc_q; kcrc_d = kcrc_q; foff_d = foff_q;
		flen_d = flen_q; flags_d = flags_q;
		bundle = '0;

		case (phase_q)
			btr_pkg::PH_HEADER, btr_pkg::PH_FHDR: begin
				cnt_d = cnt_n;
				if (cnt_q[3:0] == 4'd3) begin
					if (phase_q == btr_pkg::PH_HEADER) size_d = w; else fnum_d = w;
				end else if (cnt_q[3:0] == 4'd7) begin
					bad_d = (w != ~((phase_q == btr_pkg::PH_HEADER) ? size_q : fnum_q));
				end else if (cnt_q[3:0] == 4'd11) begin
					if (phase_q == btr_pkg::PH_HEADER) ecrc_d = w; else fchk_d = w;
				end else if (cnt_q[3:0] == 4'd15) begin
					cnt_d = '0;
					sw_d = '0;
					if (phase_q == btr_pkg::PH_HEADER) begin
						bundle.count = 2'd1;
						if (bad_q || w != ~ecrc_q || size_q < btr_pkg::MIN_SIZE
							|| size_q > {5'd0, size_limit}) begin
							bundle.r0 = mk(btr_pkg::K_SIZE_ERR, '0, '0, '0, '0);
							phase_d = btr_pkg::PH_DONE;
						end else begin
							bundle.r0 = mk(btr_pkg::K_HDR_OK, '0, '0, '0, '0);
							phase_d = btr_pkg::PH_SYNC;
						end
					end else begin
						flags_d = {dup_h, cur_h};
						foff_d = off_d;
						flen_d = len32[CB-1:0];
						kcrc_d = btr_pkg::ALL_ONES;
						ccrc_d = rcrc_q;
						phase_d = btr_pkg::PH_DATA;
					end
				end
			end
			btr_pkg::PH_SYNC: begin
				if (cnt_q[1:0] == 2'd3 && w == btr_pkg::SYNC_WORD) begin
					bundle.count = 2'd1;
					bundle.r0 = mk(btr_pkg::K_SYNC, '0, '0, '0, '0);
					phase_d = btr_pkg::PH_MAGIC;
					cnt_d = '0;
					sw_d = '0;
				end else begin
					cnt_d = {{(CB-2){1'b0}}, cnt_n[1:0]};
				end
			end
			btr_pkg::PH_MAGIC: begin
				if (w == btr_pkg::MAGIC_WORD) begin
					phase_d = btr_pkg::PH_FHDR;
					cnt_d = '0;
					sw_d = '0;
				end
			end
			btr_pkg::PH_DATA: begin
				bundle.count = 2'd1;
				bundle.r0 = mk(btr_pkg::K_WRITE,
					load_base + 32'(foff_q) + 32'(cnt_q), b, '0, '0);
				kcrc_d = kc_n;
				ccrc_d = cc_n;
				cnt_d = cnt_n;
				if (cnt_n >= flen_q) begin
					bundle.count = 2'd2;
					bundle.r1 = mk(ok_chunk ? btr_pkg::K_ACK : btr_pkg::K_NAK, '0, '0,
						(flags_q != 2'd0) ? fnum_q : nblk32, '0);
					if (ok_chunk && flags_q[0]) nblk_d = nblk_q + 17'd1;
					rcrc_d = rcrc_n;
					rcv_d = rcv_n;
					cnt_d = '0;
					sw_d = '0;
					if (32'(rcv_n) >= size_q) begin
						bundle.count = 2'd3;
						if ((rcrc_n ^ btr_pkg::ALL_ONES) == ecrc_q)
							bundle.r2 = mk(btr_pkg::K_CRC_OK, '0, '0, '0, size_q[26:0]);
						else
							bundle.r2 = mk(btr_pkg::K_CRC_ERR, '0, '0, '0, '0);
						phase_d = btr_pkg::PH_DONE;
					end else begin
						phase_d = btr_pkg::PH_MAGIC;
					end
				end
			end
			default: sw_d = '0;
		endcase
		case (bundle.count)
			2'd1: bundle.r0.last = 1'b1;
			2'd2: bundle.r1.last = 1'b1;
			2'd3: bundle.r2.last = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= btr_pkg::PH_HEADER; cnt_q <= '0; sw_q <= '0; size_q <= '0;
			ecrc_q <= '0; bad_q <= 1'b0; fnum_q <= '0; fchk_q <= '0; nblk_q <= '0;
			rcv_q <= '0; rcrc_q <= btr_pkg::ALL_ONES; ccrc_q <= btr_pkg::ALL_ONES;
			kcrc_q <= btr_pkg::ALL_ONES; foff_q <= '0; flen_q <= '0; flags_q <= '0;
		end else if (take) begin
			phase_q <= phase_d; cnt_q <= cnt_d; sw_q <= sw_d; size_q <= size_d;
			ecrc_q <= ecrc_d; bad_q <= bad_d; fnum_q <= fnum_d; fchk_q <= fchk_d;
			nblk_q <= nblk_d; rcv_q <= rcv_d; rcrc_q <= rcrc_d; ccrc_q <= ccrc_d;
			kcrc_q <= kcrc_d; foff_q <= foff_d; flen_q <= flen_d; flags_q <= flags_d;
		end
	end
endmodule
`default_nettype wire

### src/btr_out_queue.sv
`default_nettype none
`include "block_transfer_receiver_unit_defines.svh"
// Result queue: takes a bundle of up to three results, drains one per cycle while the sink is ready
module btr_out_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire btr_pkg::bundle_t bundle,
	output logic             room,
	btr_res_if.source        res
);
	localparam int DEPTH = 8;
	btr_pkg::result_t mem_q [DEPTH];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;
	logic [1:0] n_in;
	logic pop;

	assign n_in = push ? bundle.count : 2'd0;
	assign pop = res.valid && res.ready;
	// room for a full bundle even if nothing drains
	assign room = cnt_q <= 4'(DEPTH - 3);
	assign res.valid = cnt_q != 4'd0;
	assign res.kind = mem_q[rp_q].kind;
	assign res.write_address = mem_q[rp_q].write_address;
	assign res.write_data = mem_q[rp_q].write_data;
	assign res.echo_block = mem_q[rp_q].echo_block;
	assign res.total_size = mem_q[rp_q].total_size;
	assign res.last = mem_q[rp_q].last;

	always_ff @(posedge clk) begin
		if (n_in >= 2'd1) mem_q[wp_q] <= bundle.r0;
		if (n_in >= 2'd2) mem_q[wp_q + 3'd1] <= bundle.r1;
		if (n_in == 2'd3) mem_q[wp_q + 3'd2] <= bundle.r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + 3'(n_in);
			rp_q <= rp_q + 3'(pop);
			cnt_q <= cnt_q + 4'(n_in) - 4'(pop);
		end
	end

	`BTR_ASSERT(a_no_overflow, clk, arst_n, cnt_q <= 4'(DEPTH), "queue overflow")
	`BTR_ASSERT(a_push_room, clk, arst_n, push |-> room, "push without room")
	`BTR_ASSERT(a_cnt_step, clk, arst_n, !push && !pop |=> $stable(cnt_q), "count drift")
endmodule
`default_nettype wire

### src/block_transfer_receiver_unit.sv
`default_nettype none
// Block transfer receiver: one received byte per item, up to three results per byte.
// Throughput: one byte per cycle while results drain; a byte is held off only when
// the result queue lacks room for three more results.
// Results are registered in the result queue before they appear at the port.
// Reset (arst_n low, asynchronous): header phase, CRCs all ones, queue empty,
// load_base 0x10000000, size limit 0x6000000.
module block_transfer_receiver_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	btr_rx_if.sink     rx,
	btr_res_if.source  res
);
	logic [31:0] load_base_q;
	logic [26:0] max_size_q;
	logic room, take;
	btr_pkg::bundle_t bundle;

	// configuration registers; single index bit covers both registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= 32'h10000000;
			max_size_q <= 27'd100663296;
		end else if (cfg_we) begin
			case (btr_pkg::reg_idx_t'(cfg_index))
				btr_pkg::REG_LOAD_BASE: load_base_q <= cfg_wdata;
				btr_pkg::REG_MAX_SIZE: max_size_q <= cfg_wdata[26:0];
				default: ;
			endcase
		end
	end

	// accept while the queue can swallow a worst-case bundle
	assign rx.ready = room;
	assign take = rx.valid && room;

	btr_core u_core (
		.clk(clk), .arst_n(arst_n), .take(take), .b(rx.rx_byte),
		.load_base(load_base_q), .size_limit(max_size_q), .bundle(bundle)
	);

	btr_out_queue u_q (
		.clk(clk), .arst_n(arst_n), .push(take), .bundle(bundle), .room(room), .res(res)
	);
endmodule
`default_nettype wire

### test/block_transfer_receiver_unit_test.sv
`default_nettype none
// Self-checking bench for the block transfer receiver: a short table of header and
// sync bytes, then random frames (good, corrupted, out of order) until the transfer
// ends, each result checked against a cycle-free model of the loader.
module block_transfer_receiver_unit_test;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_wdata;

	btr_rx_if rx();
	btr_res_if res();

	block_transfer_receiver_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .rx(rx.sink), .res(res.source)
	);

	// directed row: a byte and, where obvious, the single result it must give
	typedef struct {
		logic [7:0]      b;
		bit              typed;
		btr_pkg::kind_t  k;
	} row_t;

	// ---- loader model state ----
	logic [31:0] m_base;
	logic [26:0] m_max;
	btr_pkg::phase_t m_ph;
	logic [10:0] m_cnt;
	logic [31:0] m_shift;
	logic [31:0] m_size;
	logic [31:0] m_crc_hdr;
	bit          m_bad;
	logic [31:0] m_fnum;
	logic [31:0] m_fchk;
	logic [16:0] m_next;
	logic [26:0] m_got;
	logic [31:0] m_run_crc;
	logic [31:0] m_cand_crc;
	logic [31:0] m_chunk_crc;
	logic [26:0] m_foff;
	logic [10:0] m_flen;
	logic [1:0]  m_flags;

	btr_pkg::result_t pending_q[$];   // results still owed by the block
	btr_pkg::result_t fresh_q[$];     // results of the byte just accepted
	logic [7:0]  frame_q[$];          // bytes of the frame being built

	int errors;
	int sent;
	int got;
	int src_idle;
	int snk_idle;
	int frames;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] crc_add(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ btr_pkg::POLY) : (c >> 1);
		return c;
	endfunction

	function automatic btr_pkg::result_t mk(input btr_pkg::kind_t k, input logic [31:0] a,
			input logic [7:0] d, input logic [31:0] blk, input logic [26:0] sz);
		btr_pkg::result_t r;
		r.kind = k;
		r.write_address = a;
		r.write_data = d;
		r.echo_block = blk;
		r.total_size = sz;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic model_reset();
		m_base = 32'h10000000;
		m_max = 27'h6000000;
		m_ph = btr_pkg::PH_HEADER;
		m_cnt = '0;
		m_shift = '0;
		m_size = '0;
		m_crc_hdr = '0;
		m_bad = 1'b0;
		m_fnum = '0;
		m_fchk = '0;
		m_next = '0;
		m_got = '0;
		m_run_crc = btr_pkg::ALL_ONES;
		m_cand_crc = btr_pkg::ALL_ONES;
		m_chunk_crc = btr_pkg::ALL_ONES;
		m_foff = '0;
		m_flen = '0;
		m_flags = '0;
	endtask

	// advance the model by one byte; results land in fresh_q
	task automatic model_byte(input logic [7:0] b);
		logic [31:0] w;
		logic [31:0] len;
		logic [31:0] resp;
		bit ok;
		bit cur;
		bit dup;
		fresh_q.delete();
		m_shift = {b, m_shift[31:8]};
		w = m_shift;
		case (m_ph)
			btr_pkg::PH_HEADER: begin
				if (m_cnt == 3) m_size = w;
				else if (m_cnt == 7) m_bad = (w != ~m_size);
				else if (m_cnt == 11) m_crc_hdr = w;
				if (m_cnt == 15) begin
					if (w != ~m_crc_hdr) m_bad = 1'b1;
					if (m_size < btr_pkg::MIN_SIZE || m_size > {5'd0, m_max}) m_bad = 1'b1;
					fresh_q.push_back(mk(m_bad ? btr_pkg::K_SIZE_ERR : btr_pkg::K_HDR_OK,
						0, 0, 0, 0));
					m_ph = m_bad ? btr_pkg::PH_DONE : btr_pkg::PH_SYNC;
					m_cnt = '0;
					m_shift = '0;
				end else
					m_cnt++;
			end
			btr_pkg::PH_SYNC: begin
				if (m_cnt[1:0] == 2'd3 && w == btr_pkg::SYNC_WORD) begin
					fresh_q.push_back(mk(btr_pkg::K_SYNC, 0, 0, 0, 0));
					m_ph = btr_pkg::PH_MAGIC;
					m_cnt = '0;
					m_shift = '0;
				end else
					m_cnt = {9'd0, m_cnt[1:0] + 2'd1};
			end
			btr_pkg::PH_MAGIC: begin
				if (w == btr_pkg::MAGIC_WORD) begin
					m_ph = btr_pkg::PH_FHDR;
					m_cnt = '0;
					m_shift = '0;
				end
			end
			btr_pkg::PH_FHDR: begin
				if (m_cnt == 3) m_fnum = w;
				else if (m_cnt == 7) m_bad = (w != ~m_fnum);
				else if (m_cnt == 11) m_fchk = w;
				if (m_cnt == 15) begin
					ok = !m_bad && (w == ~m_fchk);
					cur = ok && m_fnum == {15'd0, m_next};
					dup = ok && m_next != 0 && m_fnum == {15'd0, m_next - 17'd1};
					m_flags = {dup, cur};
					m_foff = dup ? 27'(m_fnum << btr_pkg::BLK_SHIFT) : m_got;
					len = (m_size > {5'd0, m_foff}) ? m_size - {5'd0, m_foff} : 32'd0;
					if (len > 32'(btr_pkg::BLOCK_BYTES)) len = 32'(btr_pkg::BLOCK_BYTES);
					if (len == 32'd0) len = 32'd1;
					m_flen = 11'(len);
					m_chunk_crc = btr_pkg::ALL_ONES;
					m_cand_crc = m_run_crc;
					m_ph = btr_pkg::PH_DATA;
					m_cnt = '0;
					m_shift = '0;
				end else
					m_cnt++;
			end
			btr_pkg::PH_DATA: begin
				fresh_q.push_back(mk(btr_pkg::K_WRITE,
					m_base + {5'd0, m_foff} + {21'd0, m_cnt}, b, 0, 0));
				m_chunk_crc = crc_add(m_chunk_crc, b);
				m_cand_crc = crc_add(m_cand_crc, b);
				m_cnt++;
				if (m_cnt >= m_flen) begin
					resp = (m_flags != 0) ? m_fnum : {15'd0, m_next};
					if (m_flags != 0 && (m_chunk_crc ^ btr_pkg::ALL_ONES) == m_fchk) begin
						if (m_flags[0]) begin
							m_run_crc = m_cand_crc;
							m_got = m_got + {16'd0, m_flen};
							m_next = m_next + 17'd1;
						end
						fresh_q.push_back(mk(btr_pkg::K_ACK, 0, 0, resp, 0));
					end else
						fresh_q.push_back(mk(btr_pkg::K_NAK, 0, 0, resp, 0));
					m_cnt = '0;
					m_shift = '0;
					if ({5'd0, m_got} >= m_size) begin
						if ((m_run_crc ^ btr_pkg::ALL_ONES) == m_crc_hdr)
							fresh_q.push_back(mk(btr_pkg::K_CRC_OK, 0, 0, 0, 27'(m_size)));
						else
							fresh_q.push_back(mk(btr_pkg::K_CRC_ERR, 0, 0, 0, 0));
						m_ph = btr_pkg::PH_DONE;
					end else
						m_ph = btr_pkg::PH_MAGIC;
				end
			end
			default: m_shift = '0;
		endcase
		if (fresh_q.size() > 0)
			fresh_q[fresh_q.size() - 1].last = 1'b1;
	endtask

	// hand one byte to the block; idle cycle by cycle at the current rate
	task automatic send_byte(input logic [7:0] b);
		if (sent < 90) begin
			src_idle = 38; snk_idle = 50;
		end else if (sent < 180) begin
			src_idle = 50; snk_idle = 38;
		end else begin
			src_idle = 0; snk_idle = 0;
		end
		while ($urandom_range(99) < src_idle) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(negedge clk); while (!rx.ready);
		@(posedge clk);
		sent++;
		model_byte(b);
	endtask

	function automatic void add_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			frame_q.push_back(w[8*i +: 8]);
	endfunction

	// let the block drain, then write a register while it is idle
	task automatic write_reg(input btr_pkg::reg_idx_t idx, input logic [31:0] v);
		rx.valid <= 1'b0;
		while (pending_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == btr_pkg::REG_LOAD_BASE) m_base = v;
		else m_max = v[26:0];
	endtask

	// result side: random back-pressure, compare at the falling edge
	initial res.ready = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(negedge clk) begin
		btr_pkg::result_t e;
		if (arst_n && res.valid && res.ready) begin
			got++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: expected no result, got kind %0d", $time, res.kind);
			end else begin
				e = pending_q.pop_front();
				if (res.kind !== e.kind || res.write_address !== e.write_address ||
						res.write_data !== e.write_data ||
						res.echo_block !== e.echo_block ||
						res.total_size !== e.total_size || res.last !== e.last) begin
					errors++;
					$display("%0t: exp k%0d a%h d%h b%h s%0d l%0d, got k%0d a%h d%h b%h s%0d l%0d",
						$time, e.kind, e.write_address, e.write_data, e.echo_block,
						e.total_size, e.last, res.kind, res.write_address, res.write_data,
						res.echo_block, res.total_size, res.last);
				end
			end
		end
	end

	initial begin
		row_t        rows[$];
		row_t        r;
		logic [7:0]  data[];
		logic [31:0] size;
		logic [31:0] xfer_crc;
		logic [31:0] hdr_crc;
		logic [31:0] blk;
		logic [31:0] chk;
		logic [31:0] inv_blk;
		logic [31:0] inv_chk;
		int          pick;
		int          flip;
		errors = 0; sent = 0; got = 0; frames = 0;
		src_idle = 38; snk_idle = 50;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = btr_pkg::REG_LOAD_BASE;
		cfg_wdata = '0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// payload and its whole-transfer CRC; sometimes a wrong but self-consistent CRC
		size = 32'($urandom_range(40, 110));
		data = new[size];
		xfer_crc = btr_pkg::ALL_ONES;
		foreach (data[i]) begin
			data[i] = 8'($urandom_range(255));
			xfer_crc = crc_add(xfer_crc, data[i]);
		end
		xfer_crc ^= btr_pkg::ALL_ONES;
		hdr_crc = ($urandom_range(3) == 0) ? xfer_crc ^ 32'h1 : xfer_crc;

		// size limit through its extremes, ending exactly at this transfer's size
		write_reg(btr_pkg::REG_MAX_SIZE, 32'd20);
		write_reg(btr_pkg::REG_MAX_SIZE, 32'h7ffffff);
		write_reg(btr_pkg::REG_LOAD_BASE, 32'h0);
		write_reg(btr_pkg::REG_MAX_SIZE, size);

		// directed: header, then sync phase with a misaligned sync word before the real one
		add_word(size); add_word(~size); add_word(hdr_crc); add_word(~hdr_crc);
		add_word(32'haa55ffff); add_word(32'h0000c33c); // sync bytes straddle a word here
		add_word(btr_pkg::SYNC_WORD);
		foreach (frame_q[i]) begin
			r.b = frame_q[i];
			r.typed = (i == 15) || (i == 27);
			r.k = (i == 15) ? btr_pkg::K_HDR_OK : btr_pkg::K_SYNC;
			rows.push_back(r);
		end
		frame_q.delete();
		foreach (rows[i]) begin
			send_byte(rows[i].b);
			if (rows[i].typed)
				pending_q.push_back('{kind: rows[i].k, write_address: 0, write_data: 0,
					echo_block: 0, total_size: 0, last: 1'b1});
			else
				foreach (fresh_q[j]) pending_q.push_back(fresh_q[j]);
		end

		// random frames until the transfer closes; later frames are kept sound so the
		// run stays near its planned length
		while (m_ph != btr_pkg::PH_DONE) begin
			if ($urandom_range(2) == 0)
				write_reg(btr_pkg::REG_LOAD_BASE, ($urandom_range(1) == 0) ? 32'hffffffc0
					: 32'($urandom()));
			repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(255)));
			add_word(btr_pkg::MAGIC_WORD);
			pick = (sent >= 60) ? 9 : int'($urandom_range(9));
			blk = (pick == 2) ? {15'd0, m_next} + 32'($urandom_range(1, 5))
				: {15'd0, m_next};
			chk = btr_pkg::ALL_ONES;
			for (int i = 0; i < size; i++) chk = crc_add(chk, data[i]);
			chk ^= btr_pkg::ALL_ONES;
			if (pick == 3) chk ^= 32'h80000000;
			inv_blk = (pick == 0) ? blk : ~blk;
			inv_chk = (pick == 1) ? chk : ~chk;
			add_word(blk); add_word(inv_blk); add_word(chk); add_word(inv_chk);
			flip = (pick == 4) ? int'($urandom_range(size - 1)) : -1;
			for (int i = 0; i < size; i++)
				frame_q.push_back((i == flip) ? ~data[i] : data[i]);
			while (frame_q.size() > 0) begin
				send_byte(frame_q.pop_front());
				foreach (fresh_q[j]) pending_q.push_back(fresh_q[j]);
			end
			frames++;
		end

		// once finished, the block must swallow everything silently
		for (int i = 0; i < 10 || sent < 270; i++) begin
			send_byte(8'($urandom_range(255)));
			foreach (fresh_q[j]) pending_q.push_back(fresh_q[j]);
		end
		rx.valid <= 1'b0;
		while (pending_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d frames of %0d-byte payload, %0d results checked.",
			sent, frames, size, got);
		if (errors == 0 && pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
